/* design/bps_pkg.sv */
`timescale 1ns / 1ps

package bps_pkg;

  localparam int MAX_PATTERN  = 32;
  localparam int MAX_HAYSTACK = 65536;

  localparam int NUM_WORDS   = 4;
  localparam int WORD_W      = 64;
  localparam int LEN_REG_W   = 6;
  localparam int CFG_INDEX_W = 3;
  localparam int OFFSET_W    = 16;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CNT_W = $clog2(MAX_HAYSTACK + 2);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LENGTH = 3'd0,
    REG_WORD0  = 3'd1,
    REG_WORD1  = 3'd2,
    REG_WORD2  = 3'd3,
    REG_WORD3  = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [MAX_PATTERN-1:0][7:0] bytes;
    logic [LEN_W-1:0]            length;
  } pattern_cfg_t;

endpackage

/* design/bps_cfg.sv */
`timescale 1ns / 1ps

module bps_cfg
  import bps_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]      cfg_data,
  output pattern_cfg_t           pattern
);

  logic [LEN_REG_W-1:0]                 length_reg;
  logic [NUM_WORDS-1:0][WORD_W-1:0]     words;
  logic [NUM_WORDS*WORD_W-1:0]          words_flat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_reg <= LEN_REG_W'(1);
      words      <= '0;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_LENGTH: length_reg <= cfg_data[LEN_REG_W-1:0];
        REG_WORD0:  words[0]   <= cfg_data;
        REG_WORD1:  words[1]   <= cfg_data;
        REG_WORD2:  words[2]   <= cfg_data;
        REG_WORD3:  words[3]   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign words_flat = words;

  always_comb begin
    pattern.bytes = words_flat[MAX_PATTERN*8-1:0];
    if (length_reg == '0) begin
      pattern.length = LEN_W'(1);
    end else if (LEN_REG_W'(length_reg) > LEN_REG_W'(MAX_PATTERN)) begin
      pattern.length = LEN_W'(MAX_PATTERN);
    end else begin
      pattern.length = LEN_W'(length_reg);
    end
  end

endmodule

/* design/bps_window.sv */
`timescale 1ns / 1ps

module bps_window
  import bps_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         shift,
  input  logic [7:0]   new_byte,
  input  pattern_cfg_t pattern,
  output logic         hit
);

  logic [MAX_PATTERN-1:0][7:0] recent;
  logic [MAX_PATTERN-1:0][7:0] window;
  logic [MAX_PATTERN-1:0]      byte_ok;
  logic [LEN_W-1:0]            idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      recent <= '0;
    end else if (shift) begin
      recent <= window;
    end
  end

  // The newest byte sits at position 0 of the window.
  always_comb begin
    window[0] = new_byte;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      window[k] = recent[k-1];
    end
  end

  always_comb begin
    idx = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      idx = pattern.length - LEN_W'(1) - LEN_W'(i);
      byte_ok[i] = (LEN_W'(i) >= pattern.length) ||
                   (window[idx[IDX_W-1:0]] == pattern.bytes[i]);
    end
  end

  assign hit = &byte_ok;

endmodule

/* design/byte_pattern_search.sv */
`timescale 1ns / 1ps

// Streaming search for a byte pattern of 1 to 32 bytes. One haystack byte is
// taken per cycle unless in_stall holds it off, with final_byte marking the end
// of a haystack; each byte passes an input register and then a combinational
// parallel window compare into the result register. A haystack yields exactly
// one result: the start offset of the first match, or a not-found result on
// its final byte, with length_exceeded set when the haystack ran past the
// searchable bound. Configuration writes are accepted every cycle and must be
// made while no haystack is in flight.
module byte_pattern_search
  import bps_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]      cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             hay_byte,
  input  logic                   final_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   found,
  output logic [OFFSET_W-1:0]    match_offset,
  output logic                   length_exceeded
);

  pattern_cfg_t pattern;

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             s1_final;
  logic             advance;
  logic             win_hit;

  logic [CNT_W-1:0] bytes_seen;
  logic [CNT_W-1:0] bytes_seen_next;
  logic             match_reported;
  logic             match_reported_next;

  logic [CNT_W:0]   pos_plus;
  logic [CNT_W:0]   start;
  logic             searchable;
  logic             hit_now;
  logic             produce;

  bps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pattern   (pattern)
  );

  bps_window u_window (
    .clk      (clk),
    .rst      (rst),
    .shift    (advance),
    .new_byte (s1_byte),
    .pattern  (pattern),
    .hit      (win_hit)
  );

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_byte  <= hay_byte;
      s1_final <= final_byte;
    end
  end

  always_comb begin
    pos_plus   = {1'b0, bytes_seen} + (CNT_W+1)'(1);
    start      = pos_plus - (CNT_W+1)'(pattern.length);
    searchable = !match_reported &&
                 (bytes_seen < CNT_W'(MAX_HAYSTACK)) &&
                 (pos_plus >= (CNT_W+1)'(pattern.length));
    hit_now    = searchable && win_hit;
    produce    = hit_now || (s1_final && !match_reported);

    if (s1_final) begin
      bytes_seen_next     = '0;
      match_reported_next = 1'b0;
    end else begin
      bytes_seen_next     = (bytes_seen <= CNT_W'(MAX_HAYSTACK)) ?
                            pos_plus[CNT_W-1:0] : bytes_seen;
      match_reported_next = match_reported || hit_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen     <= '0;
      match_reported <= 1'b0;
    end else if (advance) begin
      bytes_seen     <= bytes_seen_next;
      match_reported <= match_reported_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= advance && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      found           <= hit_now;
      match_offset    <= hit_now ? start[OFFSET_W-1:0] : '0;
      length_exceeded <= !hit_now && (bytes_seen >= CNT_W'(MAX_HAYSTACK));
    end
  end

endmodule
